>>> rtl/core/sprite_blit_clip_colorkey_defines.svh
// Assertion macros shared by the sprite blitter RTL
`ifndef SPRITE_BLIT_CLIP_COLORKEY_DEFINES_SVH
`define SPRITE_BLIT_CLIP_COLORKEY_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBCC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SBCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sbcc_pkg.sv
// Shared types, constants and helpers for the sprite blitter
package sbcc_pkg;

    localparam int DIM_W     = 13;
    localparam int POS_W     = 14;
    localparam int ANCHOR_W  = 12;
    localparam int ORIGIN_W  = 15;
    localparam int COL_W     = 12;
    localparam int PCT_W     = 7;
    localparam int PITCH_W   = 16;
    localparam int KEY_W     = 24;
    localparam int PIXEL_W   = 32;
    localparam int OFFSET_W  = 28;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int VPROD_W   = 20;   // sprite width times percent
    localparam int COL100_W  = 19;   // hundred times (column + 1)

    localparam logic [DIM_W-1:0]    MAX_DIM      = 13'd4096;
    localparam logic [PCT_W-1:0]    PERCENT_FULL = 7'd100;
    localparam logic [COL100_W-1:0] COL_STEP     = 19'd100;

    localparam logic [DIM_W-1:0]   DEST_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0]   DEST_HEIGHT_RST = 13'd480;
    localparam logic [PITCH_W-1:0] DEST_PITCH_RST  = 16'd2560;
    localparam logic [KEY_W-1:0]   COLOR_KEY_RST   = 24'd0;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_PIXEL = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEST_WIDTH  = 2'd0,
        CFG_DEST_HEIGHT = 2'd1,
        CFG_DEST_PITCH  = 2'd2,
        CFG_COLOR_KEY   = 2'd3
    } t_cfg_idx;

    // Draw cursor as seen by the pixel path
    typedef struct packed {
        logic                       active;
        logic                       last;
        logic                       vis_ok;
        logic                       key_on;
        logic signed [ORIGIN_W-1:0] dx;
        logic signed [ORIGIN_W-1:0] dy;
    } t_cursor;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] v);
        return (v > PERCENT_FULL) ? PERCENT_FULL : v;
    endfunction

endpackage

>>> rtl/core/sbcc_cursor.sv
// Draw cursor: latches start parameters and walks the sprite raster
`include "sprite_blit_clip_colorkey_defines.svh"

module sbcc_cursor
    import sbcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_pixel,
    input  logic [POS_W-1:0]    i_pos_x,
    input  logic [POS_W-1:0]    i_pos_y,
    input  logic [ANCHOR_W-1:0] i_anchor_x,
    input  logic [ANCHOR_W-1:0] i_anchor_y,
    input  logic [DIM_W-1:0]    i_sprite_width,
    input  logic [DIM_W-1:0]    i_sprite_height,
    input  logic [PCT_W-1:0]    i_draw_percent,
    input  logic                i_key_enable,
    output t_cursor             o_cur
);

    logic signed [ORIGIN_W-1:0] r_ox, n_ox;
    logic signed [ORIGIN_W-1:0] r_dx, n_dx;
    logic signed [ORIGIN_W-1:0] r_dy, n_dy;
    logic [DIM_W-1:0]           r_full_w, n_full_w;
    logic [DIM_W-1:0]           r_full_h, n_full_h;
    logic [VPROD_W-1:0]         r_vprod, n_vprod;
    logic [COL100_W-1:0]        r_col100, n_col100;
    logic [COL_W-1:0]           r_col, n_col;
    logic [DIM_W-1:0]           r_row, n_row;
    logic                       r_key_on, n_key_on;

    logic             active;
    logic             step;
    logic [DIM_W-1:0] col_next;
    logic [DIM_W-1:0] row_next;
    logic [DIM_W-1:0] sat_w;
    logic [PCT_W-1:0] sat_p;

    assign active   = (r_full_w != '0) && (r_row < r_full_h);
    assign step     = i_pixel && active;
    assign col_next = {1'b0, r_col} + DIM_W'(1);
    assign row_next = r_row + DIM_W'(1);
    assign sat_w    = sat_dim(i_sprite_width);
    assign sat_p    = sat_pct(i_draw_percent);

    always_comb begin
        n_ox     = r_ox;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_full_w = r_full_w;
        n_full_h = r_full_h;
        n_vprod  = r_vprod;
        n_col100 = r_col100;
        n_col    = r_col;
        n_row    = r_row;
        n_key_on = r_key_on;
        if (i_start) begin
            // origin = position minus anchor
            n_ox     = {i_pos_x[POS_W-1], i_pos_x} - ORIGIN_W'(i_anchor_x);
            n_dx     = {i_pos_x[POS_W-1], i_pos_x} - ORIGIN_W'(i_anchor_x);
            n_dy     = {i_pos_y[POS_W-1], i_pos_y} - ORIGIN_W'(i_anchor_y);
            n_full_w = sat_w;
            n_full_h = sat_dim(i_sprite_height);
            n_vprod  = VPROD_W'(sat_w) * VPROD_W'(sat_p);
            n_col100 = COL_STEP;
            n_col    = '0;
            n_row    = '0;
            n_key_on = i_key_enable;
        end else if (step) begin
            if (col_next >= r_full_w) begin
                // wrap to the next row
                n_col    = '0;
                n_row    = row_next;
                n_dx     = r_ox;
                n_dy     = r_dy + ORIGIN_W'(1);
                n_col100 = COL_STEP;
            end else begin
                n_col    = col_next[COL_W-1:0];
                n_dx     = r_dx + ORIGIN_W'(1);
                n_col100 = r_col100 + COL_STEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_w <= '0;
            r_full_h <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_key_on <= 1'b0;
        end else begin
            r_full_w <= n_full_w;
            r_full_h <= n_full_h;
            r_col    <= n_col;
            r_row    <= n_row;
            r_key_on <= n_key_on;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ox     <= n_ox;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_vprod  <= n_vprod;
        r_col100 <= n_col100;
    end

    // column lies in the visible part when 100*(col+1) <= width*percent
    assign o_cur.active = active;
    assign o_cur.last   = (col_next == r_full_w) && (row_next == r_full_h);
    assign o_cur.vis_ok = {1'b0, r_col100} <= r_vprod;
    assign o_cur.key_on = r_key_on;
    assign o_cur.dx     = r_dx;
    assign o_cur.dy     = r_dy;

    `SBCC_ASSERT_SAME(a_row_bounded, i_clk, i_rst_n, 1'b1, r_row <= r_full_h,
        "row counter ran past sprite height")
    `SBCC_ASSERT_NEXT(a_last_ends_draw, i_clk, i_rst_n, step && o_cur.last && !i_start,
        !active, "draw still active after last pixel")

endmodule

>>> rtl/core/sprite_blit_clip_colorkey.sv
// Top level of the sprite blitter with clipping and colour keying
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one word per cycle when
//   not stalled. A word with i_command = start latches origin (position minus
//   anchor), sprite size, visible percentage and key enable; it produces no
//   result. Each following word with i_command = pixel carries one sprite
//   pixel in row-major order and produces exactly one result word; pixel words
//   arriving while no draw is active are taken and dropped.
//   Output channel (o_out_valid / i_out_stall) carries write enable, byte
//   offset (x*4 + y*pitch, 28 bits, zero when not written), the pixel and a
//   last-pixel flag. o_out_valid rises in the cycle after a drawn pixel word
//   is accepted; throughput is one word per clock unless stalled, set by the
//   single output register. When the receiver stalls, the result register
//   holds its word and the input stalls only while that register is full and
//   blocked. Configuration (dest width, height, pitch, colour key) is written
//   through i_cfg_we / i_cfg_index / i_cfg_data; the user must write it only
//   while the block is idle, which the block does not enforce. Synchronous
//   active-low reset restores register defaults (640 x 480, pitch 2560,
//   key 0), empties the output register and ends any draw.
`include "sprite_blit_clip_colorkey_defines.svh"

module sprite_blit_clip_colorkey
    import sbcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_command,
    input  logic [POS_W-1:0]      i_pos_x,
    input  logic [POS_W-1:0]      i_pos_y,
    input  logic [ANCHOR_W-1:0]   i_anchor_x,
    input  logic [ANCHOR_W-1:0]   i_anchor_y,
    input  logic [DIM_W-1:0]      i_sprite_width,
    input  logic [DIM_W-1:0]      i_sprite_height,
    input  logic [PCT_W-1:0]      i_draw_percent,
    input  logic                  i_key_enable,
    input  logic [PIXEL_W-1:0]    i_pixel,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_write_enable,
    output logic [OFFSET_W-1:0]   o_dest_offset,
    output logic [PIXEL_W-1:0]    o_pixel_out,
    output logic                  o_last_pixel
);

    // configuration registers
    logic [DIM_W-1:0]   r_dest_w;
    logic [DIM_W-1:0]   r_dest_h;
    logic [PITCH_W-1:0] r_pitch;
    logic [KEY_W-1:0]   r_color_key;

    // result register
    logic                r_out_valid, n_out_valid;
    logic                r_we, n_we;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [PIXEL_W-1:0]  r_pix;
    logic                r_last;

    t_cursor cur;
    logic    in_acc;
    logic    start_acc;
    logic    pixel_acc;
    logic    emit;
    logic    out_free;
    logic    in_bounds;
    logic    keyed;

    logic [POS_W+PITCH_W-1:0] row_bytes;
    logic [OFFSET_W-1:0]      col_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_w    <= DEST_WIDTH_RST;
            r_dest_h    <= DEST_HEIGHT_RST;
            r_pitch     <= DEST_PITCH_RST;
            r_color_key <= COLOR_KEY_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DEST_WIDTH:  r_dest_w    <= i_cfg_data[DIM_W-1:0];
                CFG_DEST_HEIGHT: r_dest_h    <= i_cfg_data[DIM_W-1:0];
                CFG_DEST_PITCH:  r_pitch     <= i_cfg_data[PITCH_W-1:0];
                CFG_COLOR_KEY:   r_color_key <= i_cfg_data[KEY_W-1:0];
            endcase
        end
    end

    // Result register is free when empty or being drained this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !out_free;
    assign in_acc     = i_in_valid && out_free;
    assign start_acc  = in_acc && (t_cmd'(i_command) == CMD_START);
    assign pixel_acc  = in_acc && (t_cmd'(i_command) == CMD_PIXEL);
    assign emit       = pixel_acc && cur.active;

    sbcc_cursor u_cursor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start_acc),
        .i_pixel         (pixel_acc),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_anchor_x      (i_anchor_x),
        .i_anchor_y      (i_anchor_y),
        .i_sprite_width  (i_sprite_width),
        .i_sprite_height (i_sprite_height),
        .i_draw_percent  (i_draw_percent),
        .i_key_enable    (i_key_enable),
        .o_cur           (cur)
    );

    // Clip on left, right, top and bottom edges plus the visible-percentage cut on the right
    assign in_bounds = cur.vis_ok
                    && !cur.dx[ORIGIN_W-1]
                    && (cur.dx[POS_W-1:0] < {1'b0, r_dest_w})
                    && !cur.dy[ORIGIN_W-1]
                    && (cur.dy[POS_W-1:0] < {1'b0, r_dest_h});

    // Transparent when keying is on and RGB matches the key; alpha ignored
    assign keyed = cur.key_on && (i_pixel[KEY_W-1:0] == r_color_key);

    // One multiplier for the row base, then add the column bytes
    assign row_bytes = cur.dy[POS_W-1:0] * r_pitch;
    assign col_bytes = {{(OFFSET_W-POS_W-2){1'b0}}, cur.dx[POS_W-1:0], 2'b00};

    always_comb begin
        n_out_valid = r_out_valid;
        n_we        = r_we;
        n_offset    = r_offset;
        if (out_free) begin
            n_out_valid = emit;
            n_we        = in_bounds && !keyed;
            // drop the offset to zero when nothing is written
            n_offset    = (in_bounds && !keyed) ? (row_bytes[OFFSET_W-1:0] + col_bytes)
                                                : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Payload advances only when the register is free; hold otherwise
    always_ff @(posedge i_clk) begin
        r_we     <= n_we;
        r_offset <= n_offset;
        if (out_free) begin
            r_pix  <= i_pixel;
            r_last <= cur.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_write_enable = r_we;
    assign o_dest_offset  = r_offset;
    assign o_pixel_out    = r_pix;
    assign o_last_pixel   = r_last;

    `SBCC_ASSERT_SAME(a_stall_needs_word, i_clk, i_rst_n, o_in_stall, r_out_valid,
        "input stalled with an empty result register")
    `SBCC_ASSERT_NEXT(a_pixel_gives_word, i_clk, i_rst_n, emit, r_out_valid,
        "accepted pixel produced no result word")
    `SBCC_ASSERT_SAME(a_nowrite_zero_off, i_clk, i_rst_n, r_out_valid && !r_we,
        r_offset == '0, "offset not zero on a skipped pixel")

endmodule

>>> tb/tb_sprite_blit_clip_colorkey.sv
// Self-checking testbench for the sprite blitter with clipping and colour keying
`timescale 1ns / 1ps

module tb_sprite_blit_clip_colorkey;
    import sbcc_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_WORDS  = 120;

    // One input word as offered on the input channel
    typedef struct packed {
        t_cmd                cmd;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        logic [ANCHOR_W-1:0] anc_x;
        logic [ANCHOR_W-1:0] anc_y;
        logic [DIM_W-1:0]    spr_w;
        logic [DIM_W-1:0]    spr_h;
        logic [PCT_W-1:0]    pct;
        logic                key_en;
        logic [PIXEL_W-1:0]  pix;
    } blit_word_t;

    // One result word as expected on the output channel
    typedef struct packed {
        logic                we;
        logic [OFFSET_W-1:0] offset;
        logic [PIXEL_W-1:0]  pix;
        logic                last;
    } blit_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_command = 1'b0;
    logic [POS_W-1:0]      i_pos_x = '0;
    logic [POS_W-1:0]      i_pos_y = '0;
    logic [ANCHOR_W-1:0]   i_anchor_x = '0;
    logic [ANCHOR_W-1:0]   i_anchor_y = '0;
    logic [DIM_W-1:0]      i_sprite_width = '0;
    logic [DIM_W-1:0]      i_sprite_height = '0;
    logic [PCT_W-1:0]      i_draw_percent = '0;
    logic                  i_key_enable = 1'b0;
    logic [PIXEL_W-1:0]    i_pixel = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_write_enable;
    logic [OFFSET_W-1:0]   o_dest_offset;
    logic [PIXEL_W-1:0]    o_pixel_out;
    logic                  o_last_pixel;

    sprite_blit_clip_colorkey dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_anchor_x      (i_anchor_x),
        .i_anchor_y      (i_anchor_y),
        .i_sprite_width  (i_sprite_width),
        .i_sprite_height (i_sprite_height),
        .i_draw_percent  (i_draw_percent),
        .i_key_enable    (i_key_enable),
        .i_pixel         (i_pixel),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_write_enable  (o_write_enable),
        .o_dest_offset   (o_dest_offset),
        .o_pixel_out     (o_pixel_out),
        .o_last_pixel    (o_last_pixel)
    );

    // Words waiting for the driver, and results waiting for the output channel
    blit_word_t   pending_words[$];
    blit_result_t predicted_px[$];
    blit_word_t   drv_word;
    logic         in_fire = 1'b0;

    // Idling rates of the two sides, in percent
    int send_gap_pct = 0;
    int hold_pct     = 0;

    // Shadow copy of the surface registers
    int unsigned surf_w     = 640;
    int unsigned surf_h     = 480;
    int unsigned surf_pitch = 2560;
    logic [KEY_W-1:0] surf_key = '0;

    // Shadow copy of the draw cursor
    int          org_x = 0;
    int          org_y = 0;
    int unsigned spr_w = 0;
    int unsigned spr_h = 0;
    int unsigned vis_w = 0;
    bit          key_on = 1'b0;
    int unsigned col = 0;
    int unsigned row = 0;

    int errors = 0;
    int cycles = 0;
    int stim_count = 0;
    int n_taken = 0;
    int n_starts = 0;
    int n_results = 0;
    int n_writes = 0;
    int n_keyed = 0;
    int n_ends = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Work out the result of one accepted word and advance the cursor
    task automatic predict_blit(input blit_word_t w);
        int unsigned pct;
        int dx, dy;
        bit on_surf, keyed;
        longint unsigned off;
        blit_result_t r;
        n_taken++;
        if (w.cmd == CMD_START) begin
            pct = (w.pct > PERCENT_FULL) ? int'(PERCENT_FULL) : w.pct;
            org_x = int'($signed(w.pos_x)) - int'(w.anc_x);
            org_y = int'($signed(w.pos_y)) - int'(w.anc_y);
            spr_w = (w.spr_w > MAX_DIM) ? int'(MAX_DIM) : w.spr_w;
            spr_h = (w.spr_h > MAX_DIM) ? int'(MAX_DIM) : w.spr_h;
            vis_w = spr_w * pct / 100;
            key_on = w.key_en;
            col = 0;
            row = 0;
            n_starts++;
            return;
        end
        // drop pixels that arrive with no draw in progress
        if (spr_w == 0 || row >= spr_h) return;
        dx = org_x + int'(col);
        dy = org_y + int'(row);
        on_surf = (col < vis_w) && dx >= 0 && dx < int'(surf_w) &&
                  dy >= 0 && dy < int'(surf_h);
        keyed = key_on && (w.pix[KEY_W-1:0] == surf_key);
        r.we = on_surf && !keyed;
        off = longint'(dx) * 4 + longint'(dy) * longint'(surf_pitch);
        r.offset = r.we ? off[OFFSET_W-1:0] : '0;
        r.pix = w.pix;
        r.last = (col + 1 == spr_w) && (row + 1 == spr_h);
        predicted_px.push_back(r);
        n_results++;
        if (r.we) n_writes++;
        if (on_surf && keyed) n_keyed++;
        if (r.last) n_ends++;
        col++;
        if (col >= spr_w) begin
            col = 0;
            row++;
        end
    endtask

    // Check the output channel, then take the input word of this edge
    always @(posedge i_clk) begin
        blit_result_t exp_r;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (predicted_px.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected: we %0b off %0h pix %0h last %0b",
                             $time, o_write_enable, o_dest_offset, o_pixel_out, o_last_pixel);
                end else begin
                    exp_r = predicted_px.pop_front();
                    if (o_write_enable !== exp_r.we) begin
                        errors++;
                        $display("%0t: write_enable expected %0b got %0b",
                                 $time, exp_r.we, o_write_enable);
                    end
                    if (o_dest_offset !== exp_r.offset) begin
                        errors++;
                        $display("%0t: dest_offset expected %0h got %0h",
                                 $time, exp_r.offset, o_dest_offset);
                    end
                    if (o_pixel_out !== exp_r.pix) begin
                        errors++;
                        $display("%0t: pixel_out expected %0h got %0h",
                                 $time, exp_r.pix, o_pixel_out);
                    end
                    if (o_last_pixel !== exp_r.last) begin
                        errors++;
                        $display("%0t: last_pixel expected %0b got %0b",
                                 $time, exp_r.last, o_last_pixel);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                predict_blit(drv_word);
                in_fire <= 1'b1;
            end else begin
                in_fire <= 1'b0;
            end
        end else begin
            in_fire <= 1'b0;
        end
    end

    // Input driver: advance to the next word once the current one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                drv_word = pending_words.pop_front();
                i_in_valid      <= 1'b1;
                i_command       <= drv_word.cmd;
                i_pos_x         <= drv_word.pos_x;
                i_pos_y         <= drv_word.pos_y;
                i_anchor_x      <= drv_word.anc_x;
                i_anchor_y      <= drv_word.anc_y;
                i_sprite_width  <= drv_word.spr_w;
                i_sprite_height <= drv_word.spr_h;
                i_draw_percent  <= drv_word.pct;
                i_key_enable    <= drv_word.key_en;
                i_pixel         <= drv_word.pix;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < hold_pct);
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic blit_word_t rand_word();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return bits[$bits(blit_word_t)-1:0];
    endfunction

    // Random pixel, often hitting the colour key under a random alpha byte
    function automatic logic [PIXEL_W-1:0] rand_pixel();
        logic [PIXEL_W-1:0] p;
        p = $urandom;
        if ($urandom_range(0, 3) == 0) p[KEY_W-1:0] = surf_key;
        return p;
    endfunction

    function automatic int clamp_pos(input int v);
        return (v < -8192) ? -8192 : ((v > 8191) ? 8191 : v);
    endfunction

    task automatic push_pixel(input logic [PIXEL_W-1:0] pix, input bit counts);
        blit_word_t w;
        w = rand_word();
        w.cmd = CMD_PIXEL;
        w.pix = pix;
        pending_words.push_back(w);
        if (counts) stim_count++;
    endtask

    task automatic push_start(input int px, input int py, input int ax, input int ay,
                              input int sw, input int sh, input int pct, input bit key);
        blit_word_t w;
        w = rand_word();
        w.cmd    = CMD_START;
        w.pos_x  = px[POS_W-1:0];
        w.pos_y  = py[POS_W-1:0];
        w.anc_x  = ax[ANCHOR_W-1:0];
        w.anc_y  = ay[ANCHOR_W-1:0];
        w.spr_w  = sw[DIM_W-1:0];
        w.spr_h  = sh[DIM_W-1:0];
        w.pct    = pct[PCT_W-1:0];
        w.key_en = key;
        pending_words.push_back(w);
        stim_count++;
    endtask

    // Small sprite placed so that it often straddles a surface edge; cut short on request
    task automatic gen_sprite(input bit cut);
        int sw, sh, ax, ay, px, py, pct, n;
        sw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
        sh = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
        ax = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, sw);
        ay = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, sh);
        if ($urandom_range(0, 3) == 0) begin
            px = $urandom_range(0, 16383);
            py = $urandom_range(0, 16383);
        end else begin
            px = clamp_pos(int'($urandom_range(0, surf_w + 2 * sw)) - sw + ax);
            py = clamp_pos(int'($urandom_range(0, surf_h + 2 * sh)) - sh + ay);
        end
        pct = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 127) : 100;
        push_start(px, py, ax, ay, sw, sh, pct, $urandom_range(0, 1));
        n = cut ? $urandom_range(0, sw * sh - 1) : sw * sh;
        for (int i = 0; i < n; i++) push_pixel(rand_pixel(), 1'b1);
    endtask

    // Hold until every word is taken and every result has come back
    task automatic wait_idle();
        while (pending_words.size() != 0 || i_in_valid || predicted_px.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_DEST_WIDTH:  surf_w = val & 32'h1fff;
            CFG_DEST_HEIGHT: surf_h = val & 32'h1fff;
            CFG_DEST_PITCH:  surf_pitch = val & 32'hffff;
            CFG_COLOR_KEY:   surf_key = val[KEY_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned cw, ch, cp, ck;
        int r;
        bit open_draw;
        blit_word_t w;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on the reset surface (640 x 480, pitch 2560, key 0)
        send_gap_pct = 34;
        hold_pct = 56;
        push_pixel(32'hdead_beef, 1'b1);                 // pixel before any draw
        push_start(0, 0, 0, 0, 2, 2, 100, 1'b1);
        push_pixel(32'hff00_0000, 1'b1);                 // matches the key: skip
        push_pixel(32'h00ff_ffff, 1'b1);
        push_pixel(32'h1234_5678, 1'b1);
        push_pixel(32'h8000_0001, 1'b1);                 // last pixel
        push_pixel(32'h0000_0000, 1'b1);                 // pixel after the draw ends
        push_start(5, 5, 0, 0, 0, 3, 100, 1'b0);         // zero width
        push_pixel(32'h5555_aaaa, 1'b1);
        push_start(5, 5, 0, 0, 3, 0, 100, 1'b0);         // zero height
        push_pixel(32'haaaa_5555, 1'b1);
        // most negative origin, oversized sprite, percent above hundred
        push_start(-8192, -8192, 4095, 4095, 8191, 8191, 127, 1'b0);
        push_pixel(32'hffff_ffff, 1'b1);
        push_pixel(32'h0123_4567, 1'b1);
        // far corner, half width visible
        push_start(8191, 8191, 0, 0, 3, 1, 50, 1'b0);
        for (int i = 0; i < 3; i++) push_pixel($urandom, 1'b1);
        // straddle the right edge
        push_start(638, 478, 0, 0, 3, 2, 100, 1'b1);
        for (int i = 0; i < 6; i++) push_pixel($urandom | 32'h1, 1'b1);
        wait_idle();

        for (int k = 0; k < 6; k++) begin
            case (k)
                0: begin cw = 640;  ch = 480;  cp = 2560;  ck = $urandom_range(0, 24'hffffff); end
                1: begin cw = 1;    ch = 1;    cp = 4;     ck = 0; end
                2: begin cw = 4096; ch = 4096; cp = 65535; ck = 24'hffffff; end
                3: begin cw = 8191; ch = 8191; cp = 65535; ck = $urandom_range(0, 24'hffffff); end
                4: begin cw = 0;    ch = 100;  cp = 400;   ck = $urandom_range(0, 24'hffffff); end
                default: begin
                    cw = $urandom_range(1, 64);
                    ch = $urandom_range(1, 64);
                    cp = $urandom_range(4, 65535);
                    ck = $urandom_range(0, 24'hffffff);
                end
            endcase
            write_reg(CFG_DEST_WIDTH, cw);
            write_reg(CFG_DEST_HEIGHT, ch);
            write_reg(CFG_DEST_PITCH, cp);
            write_reg(CFG_COLOR_KEY, ck);

            // receiver idles more first, then the sender, then neither
            send_gap_pct = (k < 2) ? 34 : ((k < 4) ? 56 : 0);
            hold_pct     = (k < 2) ? 56 : ((k < 4) ? 34 : 0);

            stim_count = 0;
            open_draw = 1'b1;
            while (stim_count < PHASE_WORDS) begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    gen_sprite(1'b0);
                    open_draw = 1'b0;
                end else if (r < 85) begin
                    gen_sprite(1'b1);
                    open_draw = 1'b1;
                end else if (r < 92 && !open_draw) begin
                    // stray pixels with no draw in progress
                    for (int i = $urandom_range(1, 3); i > 0; i--) push_pixel($urandom, 1'b0);
                end else if (r < 96) begin
                    // zero-size sprite swallows the pixels after it
                    if ($urandom_range(0, 1))
                        push_start($urandom, $urandom, $urandom, $urandom, 0,
                                   $urandom_range(0, 8191), $urandom_range(0, 127),
                                   $urandom_range(0, 1));
                    else
                        push_start($urandom, $urandom, $urandom, $urandom,
                                   $urandom_range(1, 8191), 0, $urandom_range(0, 127),
                                   $urandom_range(0, 1));
                    for (int i = $urandom_range(1, 3); i > 0; i--) push_pixel($urandom, 1'b0);
                    open_draw = 1'b0;
                end else begin
                    // start with every field random, a few pixels, then abandon it
                    w = rand_word();
                    w.cmd = CMD_START;
                    pending_words.push_back(w);
                    stim_count++;
                    for (int i = $urandom_range(0, 3); i > 0; i--) push_pixel(rand_pixel(), 1'b1);
                    open_draw = 1'b1;
                end
            end
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        $display("summary: %0d words taken, %0d sprite starts, %0d pixel results",
                 n_taken, n_starts, n_results);
        $display("summary: %0d writes, %0d key drops, %0d sprite ends over 7 surface settings",
                 n_writes, n_keyed, n_ends);
        if (errors == 0 && predicted_px.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
